>>> hdl/pti_pkg.sv
// ----------------------------------------------------------------------------
// pti_pkg
// Types and constants shared by the page table insert core.
// ----------------------------------------------------------------------------
package pti_pkg;

	localparam int TABLE_PAGES_DEF = 16;
	localparam int ENTRIES_PER_TABLE = 512;
	localparam int IDX_W = 9;
	localparam int STEP_W = 4;
	localparam int LINK_W = 40;

	localparam int SHIFT_L0 = 39;
	localparam int SHIFT_L1 = 30;
	localparam int SHIFT_L2 = 21;
	localparam int SHIFT_L3 = 12;

	localparam logic [11:0] LINK_BITS = 12'h007;
	localparam logic [IDX_W-1:0] IDX_LAST = 9'h1FF;
	localparam logic [4:0] NP_STUCK = 5'd31;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_PAGE = 2'd1,
		ST_OUTSIDE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CFG_BASE  = 2'd0,
		CFG_ROOT  = 2'd1,
		CFG_FIRST = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		WS_NONE  = 3'd0,
		WS_CLEAR = 3'd1,
		WS_LINK  = 3'd2,
		WS_ZERO  = 3'd3,
		WS_LEAF  = 3'd4
	} wsel_t;

	typedef enum logic [3:0] {
		C_NEVER    = 4'd0,
		C_ALWAYS   = 4'd1,
		C_START    = 4'd2,
		C_ROOT_BAD = 4'd3,
		C_PRESENT  = 4'd4,
		C_NP_BAD   = 4'd5,
		C_DEC_BAD  = 4'd6,
		C_ZERO_END = 4'd7,
		C_CLR_END  = 4'd8,
		C_LAST_LVL = 4'd9
	} cond_t;

	typedef struct packed {
		logic [47:0] virtual_address;
		logic [51:0] physical_address;
		logic [63:0] leaf_flags;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [1:0] tables_created;
	} rsp_t;

	typedef struct packed {
		logic              idle;
		logic              done;
		logic              ld_req;
		logic              rd_en;
		wsel_t             wsel;
		logic              cnt_clr;
		logic              cnt_inc;
		logic              ld_root;
		logic              ld_page;
		logic              lvl_inc;
		logic              alloc;
		logic              st_set;
		status_t           st_val;
		cond_t             cond;
		logic              neg;
		logic [STEP_W-1:0] target;
	} ctl_t;

	typedef struct packed {
		logic root_bad;
		logic present;
		logic np_bad;
		logic dec_bad;
		logic zero_end;
		logic clr_end;
		logic last_lvl;
	} flg_t;

endpackage

>>> hdl/pti_store.sv
// ----------------------------------------------------------------------------
// pti_store
// Table page store: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module pti_store import pti_pkg::*; #(
	parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
	input  logic clk,
	input  logic we,
	input  logic [((TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1) + IDX_W - 1:0] waddr,
	input  logic [63:0] wdata,
	input  logic re,
	input  logic [((TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1) + IDX_W - 1:0] raddr,
	output logic [63:0] rdata
);

	localparam int STORE_ENTRIES = TABLE_PAGES * ENTRIES_PER_TABLE;

	logic [63:0] mem_q [STORE_ENTRIES];
	logic [63:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/pti_dp.sv
// ----------------------------------------------------------------------------
// pti_dp
// Walk datapath: request and configuration registers, slot address,
// link decode, allocator and the table store.
// ----------------------------------------------------------------------------
module pti_dp import pti_pkg::*; #(
	parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_t        ctl,
	input  logic        start,
	input  req_t        req,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [51:0] cfg_data,
	output flg_t        flg,
	output rsp_t        rsp
);

	localparam int PAGE_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
	localparam int ADDR_W = PAGE_W + IDX_W;
	localparam int STORE_ENTRIES = TABLE_PAGES * ENTRIES_PER_TABLE;
	localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(STORE_ENTRIES - 1);

	logic [LINK_W-1:0] base_q;
	logic [3:0]        root_q;
	logic [4:0]        np_q;
	req_t              req_q;
	logic [PAGE_W-1:0] page_q;
	logic [PAGE_W-1:0] zpage_q;
	logic [1:0]        lvl_q;
	logic [ADDR_W-1:0] cnt_q;
	status_t           status_q;
	logic [1:0]        created_q;

	logic [IDX_W-1:0]  idx;
	logic [ADDR_W-1:0] slot;
	logic [63:0]       rdata;
	logic [LINK_W:0]   diff;
	logic [LINK_W-1:0] link_addr;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [63:0]       wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			root_q <= '0;
			np_q   <= 5'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BASE:  base_q <= cfg_data[51:12];
				CFG_ROOT:  root_q <= cfg_data[3:0];
				CFG_FIRST: np_q   <= cfg_data[4:0];
				default: ;
			endcase
		end else if (ctl.alloc) begin
			np_q <= np_q + 5'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			lvl_q <= '0;
		end else begin
			if (ctl.cnt_clr) begin
				cnt_q <= '0;
			end else if (ctl.cnt_inc) begin
				cnt_q <= cnt_q + ADDR_W'(1);
			end
			if (ctl.ld_req && start) begin
				lvl_q <= '0;
			end else if (ctl.lvl_inc) begin
				lvl_q <= lvl_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_req && start) begin
			req_q     <= req;
			status_q  <= ST_OK;
			created_q <= '0;
		end else begin
			if (ctl.st_set) begin
				status_q <= ctl.st_val;
			end
			if (ctl.alloc) begin
				created_q <= created_q + 2'd1;
			end
		end
		if (ctl.alloc) begin
			zpage_q <= PAGE_W'(np_q);
		end
		if (ctl.ld_root) begin
			page_q <= PAGE_W'(root_q);
		end else if (ctl.ld_page) begin
			page_q <= diff[PAGE_W-1:0];
		end
	end

	always_comb begin
		case (lvl_q)
			2'd0:    idx = req_q.virtual_address[SHIFT_L0 +: IDX_W];
			2'd1:    idx = req_q.virtual_address[SHIFT_L1 +: IDX_W];
			2'd2:    idx = req_q.virtual_address[SHIFT_L2 +: IDX_W];
			default: idx = req_q.virtual_address[SHIFT_L3 +: IDX_W];
		endcase
	end

	assign slot      = {page_q, idx};
	assign diff      = {1'b0, rdata[51:12]} - {1'b0, base_q};
	assign link_addr = base_q + LINK_W'(np_q);

	always_comb begin
		we    = 1'b1;
		waddr = slot;
		wdata = '0;
		case (ctl.wsel)
			WS_CLEAR: waddr = cnt_q;
			WS_LINK:  wdata = {12'h000, link_addr, LINK_BITS};
			WS_ZERO:  waddr = {zpage_q, cnt_q[IDX_W-1:0]};
			WS_LEAF:  wdata = {12'h000, req_q.physical_address} | req_q.leaf_flags;
			default:  we = 1'b0;
		endcase
	end

	pti_store #(
		.TABLE_PAGES(TABLE_PAGES)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (ctl.rd_en),
		.raddr(slot),
		.rdata(rdata)
	);

	assign flg.root_bad = {7'b0, root_q} >= 11'(TABLE_PAGES);
	assign flg.present  = rdata[0];
	assign flg.np_bad   = ({6'b0, np_q} >= 11'(TABLE_PAGES)) || (np_q == NP_STUCK);
	assign flg.dec_bad  = diff[LINK_W] || (diff[LINK_W-1:0] >= LINK_W'(TABLE_PAGES));
	assign flg.zero_end = cnt_q[IDX_W-1:0] == IDX_LAST;
	assign flg.clr_end  = cnt_q == ADDR_LAST;
	assign flg.last_lvl = lvl_q == 2'd3;

	assign rsp.status         = status_q;
	assign rsp.tables_created = created_q;

endmodule

>>> hdl/pti_seq.sv
// ----------------------------------------------------------------------------
// pti_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module pti_seq import pti_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  flg_t flg,
	output ctl_t ctl
);

	localparam logic [STEP_W-1:0] S_CLR   = 4'd0;
	localparam logic [STEP_W-1:0] S_IDLE  = 4'd1;
	localparam logic [STEP_W-1:0] S_ROOT  = 4'd2;
	localparam logic [STEP_W-1:0] S_RD    = 4'd3;
	localparam logic [STEP_W-1:0] S_CHK   = 4'd4;
	localparam logic [STEP_W-1:0] S_NPCHK = 4'd5;
	localparam logic [STEP_W-1:0] S_LINK  = 4'd6;
	localparam logic [STEP_W-1:0] S_ZERO  = 4'd7;
	localparam logic [STEP_W-1:0] S_RDBK  = 4'd8;
	localparam logic [STEP_W-1:0] S_DEC   = 4'd9;
	localparam logic [STEP_W-1:0] S_NEXT  = 4'd10;
	localparam logic [STEP_W-1:0] S_LEAF  = 4'd11;
	localparam logic [STEP_W-1:0] S_FAIL1 = 4'd12;
	localparam logic [STEP_W-1:0] S_FAIL2 = 4'd13;
	localparam logic [STEP_W-1:0] S_DONE  = 4'd14;

	function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
		ctl_t w;
		w = '0;
		case (step)
			S_CLR: begin
				w.wsel = WS_CLEAR; w.cnt_inc = 1'b1;
				w.cond = C_CLR_END; w.neg = 1'b1; w.target = S_CLR;
			end
			S_IDLE: begin
				w.idle = 1'b1; w.ld_req = 1'b1; w.cnt_clr = 1'b1;
				w.cond = C_START; w.neg = 1'b1; w.target = S_IDLE;
			end
			S_ROOT: begin
				w.ld_root = 1'b1; w.cond = C_ROOT_BAD; w.target = S_FAIL2;
			end
			S_RD: begin
				w.rd_en = 1'b1;
			end
			S_CHK: begin
				w.cond = C_PRESENT; w.target = S_DEC;
			end
			S_NPCHK: begin
				w.cond = C_NP_BAD; w.target = S_FAIL1;
			end
			S_LINK: begin
				w.wsel = WS_LINK; w.alloc = 1'b1; w.cnt_clr = 1'b1;
			end
			S_ZERO: begin
				w.wsel = WS_ZERO; w.cnt_inc = 1'b1;
				w.cond = C_ZERO_END; w.neg = 1'b1; w.target = S_ZERO;
			end
			S_RDBK: begin
				w.rd_en = 1'b1;
			end
			S_DEC: begin
				w.cond = C_DEC_BAD; w.target = S_FAIL2;
			end
			S_NEXT: begin
				w.ld_page = 1'b1; w.lvl_inc = 1'b1;
			end
			S_LEAF: begin
				w.cond = C_LAST_LVL; w.neg = 1'b1; w.target = S_RD;
			end
			S_FAIL1: begin
				w.st_set = 1'b1; w.st_val = ST_NO_PAGE;
				w.cond = C_ALWAYS; w.target = S_DONE;
			end
			S_FAIL2: begin
				w.st_set = 1'b1; w.st_val = ST_OUTSIDE;
			end
			S_DONE: begin
				w.done = 1'b1; w.cond = C_ALWAYS; w.target = S_IDLE;
			end
			default: begin
				w.cond = C_ALWAYS; w.target = S_IDLE;
			end
		endcase
		return w;
	endfunction

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] leaf_step;
	logic              hit;

	// The leaf write shares its step with the level test: once the level
	// count reaches three the slot points at the leaf and the write is made.
	always_comb begin
		ctl = ucode(step_q);
		if (step_q == S_LEAF && flg.last_lvl) begin
			ctl.wsel   = WS_LEAF;
			ctl.cond   = C_ALWAYS;
			ctl.neg    = 1'b0;
			ctl.target = S_DONE;
		end
	end

	always_comb begin
		case (ctl.cond)
			C_ALWAYS:   hit = 1'b1;
			C_START:    hit = start;
			C_ROOT_BAD: hit = flg.root_bad;
			C_PRESENT:  hit = flg.present;
			C_NP_BAD:   hit = flg.np_bad;
			C_DEC_BAD:  hit = flg.dec_bad;
			C_ZERO_END: hit = flg.zero_end;
			C_CLR_END:  hit = flg.clr_end;
			C_LAST_LVL: hit = flg.last_lvl;
			default:    hit = 1'b0;
		endcase
	end

	assign leaf_step = (hit ^ ctl.neg) ? ctl.target : step_q + 4'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_CLR;
		end else begin
			step_q <= leaf_step;
		end
	end

endmodule

>>> hdl/four_level_page_table_insert_core.sv
// ----------------------------------------------------------------------------
// four_level_page_table_insert_core
// Maps one virtual page per command into a four-level radix page table held
// in a local store, creating missing table levels from a bump allocator.
//
// Channel   Direction  Handshake                  Payload
// command   in         start high, busy low       req (req_t)
// result    out        done strobe, one cycle     rsp (rsp_t)
// config    in         cfg_we, cfg_index          cfg_data (52 bits)
//
// Each new table page that a command creates is zeroed one entry per cycle
// through the store's single write port. After reset the store is cleared
// one entry per cycle, all TABLE_PAGES * 512 entries, with busy high;
// configuration writes are taken meanwhile.
// The result beat cannot be stalled; busy drops the cycle after done.
// ----------------------------------------------------------------------------
module four_level_page_table_insert_core import pti_pkg::*; #(
	parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	output logic        done,
	output rsp_t        rsp,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [51:0] cfg_data
);

	ctl_t ctl;
	flg_t flg;

	pti_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.flg   (flg),
		.ctl   (ctl)
	);

	pti_dp #(
		.TABLE_PAGES(TABLE_PAGES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.start    (start),
		.req      (req),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.flg      (flg),
		.rsp      (rsp)
	);

	assign busy = !ctl.idle;
	assign done = ctl.done;

endmodule

>>> hdl/pti_chk.sv
// ----------------------------------------------------------------------------
// pti_chk
// Port-level checks of the command and result beats of the insert core.
// ----------------------------------------------------------------------------
module pti_chk import pti_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t rsp
);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result beat while idle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("core stayed busy after result beat");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done)) else $error("command beat not taken up");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.status == ST_OK || rsp.status == ST_NO_PAGE ||
		rsp.status == ST_OUTSIDE)) else $error("result status code unused");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !done)
		else $error("result beat without a command");

endmodule

bind four_level_page_table_insert_core pti_chk u_chk (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.rsp   (rsp)
);
